>>> rtl/mrtf_pkg.sv
// Shared types and constants of the methylation read threshold filter.
package mrtf_pkg;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 17;
	localparam int unsigned MASK_W     = 16;
	localparam int unsigned FRAC_W     = 17;
	localparam int unsigned FRAC_SHIFT = 16;
	localparam int unsigned NUM_CNT    = 4;

	localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CHECK_MODE   = 3'd0,
		CFG_CTX_METH     = 3'd1,
		CFG_CTX_UNMETH   = 3'd2,
		CFG_OOCTX_METH   = 3'd3,
		CFG_OOCTX_UNMETH = 3'd4,
		CFG_MIN_CTX_CNT  = 3'd5,
		CFG_MIN_CTX_FRAC = 3'd6,
		CFG_MAX_OOC_FRAC = 3'd7
	} cfg_idx_t;

	// counter slots
	localparam int unsigned CNT_CM = 0;
	localparam int unsigned CNT_CU = 1;
	localparam int unsigned CNT_OM = 2;
	localparam int unsigned CNT_OU = 3;

	// check_mode bits
	localparam int unsigned MODE_FILT = 0;
	localparam int unsigned MODE_THR  = 1;

	typedef logic [1:0] verdict_t;
	localparam verdict_t VERDICT_FAIL = 2'd0;
	localparam verdict_t VERDICT_PASS = 2'd1;
	localparam verdict_t VERDICT_EXCL = 2'd2;

endpackage

>>> rtl/mrtf_in_if.sv
// Read byte channel: one packed read byte per beat.
interface mrtf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] packed_byte;
	logic       has_byte;
	logic       last;

	modport source (output valid, packed_byte, has_byte, last, input ready);
	modport sink (input valid, packed_byte, has_byte, last, output ready);
endinterface

>>> rtl/mrtf_out_if.sv
// Verdict channel: one verdict per read.
interface mrtf_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] verdict;

	modport source (output valid, verdict, input ready);
	modport sink (input valid, verdict, output ready);
endinterface

>>> rtl/methylation_read_threshold_filter.sv
// Methylation read threshold filter: per-read context counting and verdict.
//
// read_beat carries one packed read byte per beat (packed_byte, has_byte,
// last). The low nibble of each valid byte is tested against four code
// masks and bumps up to four saturating counters. The beat marked last
// closes the read: its counts move into a three-stage pipe (snapshot and
// sums, fraction products, compares) and the counters clear for the next
// read. The verdict passes the s1, s2 and output registers to result.
// A beat is taken every cycle while result is not stalled; reads of any
// length, even one beat each, stream at one beat per cycle.
// When result is valid and not ready, the whole pipe and read_beat.ready
// hold until the verdict is taken. Fraction limits are compared by
// cross-multiplying against the Q1.16 register values (17 x 17+ bits).
// The cfg port writes a register on any cycle cfg_we is high; it is meant
// to be used only while no read is in progress.
// Reset clears the counters and pipe, and loads register defaults
// (all zero, max_ooctx_frac = 1.0).
module methylation_read_threshold_filter
	import mrtf_pkg::*;
#(
	parameter int unsigned COUNT_WIDTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	mrtf_in_if.sink               read_beat,
	mrtf_out_if.source            result
);

	localparam int unsigned CW = COUNT_WIDTH;
	localparam int unsigned SW = CW + 1;
	localparam int unsigned PW = SW + FRAC_W;

	logic [1:0]        check_mode_q;
	logic [MASK_W-1:0] mask_q [NUM_CNT];
	logic [MASK_W-1:0] min_ctx_count_q;
	logic [FRAC_W-1:0] min_ctx_frac_q;
	logic [FRAC_W-1:0] max_ooctx_frac_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			check_mode_q     <= '0;
			for (int i = 0; i < NUM_CNT; i++) mask_q[i] <= '0;
			min_ctx_count_q  <= '0;
			min_ctx_frac_q   <= '0;
			max_ooctx_frac_q <= FRAC_ONE;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_CHECK_MODE:   check_mode_q           <= cfg_data[1:0];
				CFG_CTX_METH:     mask_q[CNT_CM]         <= cfg_data[MASK_W-1:0];
				CFG_CTX_UNMETH:   mask_q[CNT_CU]         <= cfg_data[MASK_W-1:0];
				CFG_OOCTX_METH:   mask_q[CNT_OM]         <= cfg_data[MASK_W-1:0];
				CFG_OOCTX_UNMETH: mask_q[CNT_OU]         <= cfg_data[MASK_W-1:0];
				CFG_MIN_CTX_CNT:  min_ctx_count_q        <= cfg_data[MASK_W-1:0];
				CFG_MIN_CTX_FRAC: min_ctx_frac_q         <= cfg_data[FRAC_W-1:0];
				CFG_MAX_OOC_FRAC: max_ooctx_frac_q       <= cfg_data[FRAC_W-1:0];
				default: ;
			endcase
		end
	end

	// flow control: the pipe freezes while the verdict waits
	logic stall;
	logic beat_acc;
	assign stall           = result.valid && !result.ready;
	assign read_beat.ready = !stall;
	assign beat_acc        = read_beat.valid && read_beat.ready;

	// counters
	logic [CW-1:0] cnt_q   [NUM_CNT];
	logic [CW-1:0] cnt_nxt [NUM_CNT];
	logic [3:0]    code;
	assign code = read_beat.packed_byte[3:0];

	always_comb begin
		for (int i = 0; i < NUM_CNT; i++) begin
			cnt_nxt[i] = cnt_q[i];
			if (read_beat.has_byte && mask_q[i][code] && (cnt_q[i] != {CW{1'b1}}))
				cnt_nxt[i] = cnt_q[i] + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CNT; i++) cnt_q[i] <= '0;
		end else if (beat_acc) begin
			for (int i = 0; i < NUM_CNT; i++)
				cnt_q[i] <= read_beat.last ? '0 : cnt_nxt[i];
		end
	end

	// stage 1: snapshot of the closed read and sums
	logic          valid_s1;
	logic [CW-1:0] cm_s1, om_s1;
	logic [SW-1:0] ctx_all_s1, ooc_all_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else if (!stall) valid_s1 <= beat_acc && read_beat.last;
	end

	always_ff @(posedge clk) begin
		if (beat_acc && read_beat.last) begin
			cm_s1      <= cnt_nxt[CNT_CM];
			om_s1      <= cnt_nxt[CNT_OM];
			ctx_all_s1 <= SW'(cnt_nxt[CNT_CM]) + SW'(cnt_nxt[CNT_CU]);
			ooc_all_s1 <= SW'(cnt_nxt[CNT_OM]) + SW'(cnt_nxt[CNT_OU]);
		end
	end

	// stage 2: fraction products
	logic          valid_s2;
	logic [CW-1:0] cm_s2, om_s2;
	logic [SW-1:0] ctx_all_s2;
	logic [PW-1:0] ctx_prod_s2, ooc_prod_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s2 <= 1'b0;
		else if (!stall) valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (!stall && valid_s1) begin
			cm_s2       <= cm_s1;
			om_s2       <= om_s1;
			ctx_all_s2  <= ctx_all_s1;
			ctx_prod_s2 <= PW'(min_ctx_frac_q) * PW'(ctx_all_s1);
			ooc_prod_s2 <= PW'(max_ooctx_frac_q) * PW'(ooc_all_s1);
		end
	end

	// stage 3: compares and verdict
	logic          excl, thr_fail;
	logic [PW-1:0] cm_scaled, om_scaled;
	verdict_t      verdict_d;

	assign cm_scaled = PW'({cm_s2, {FRAC_SHIFT{1'b0}}});
	assign om_scaled = PW'({om_s2, {FRAC_SHIFT{1'b0}}});

	always_comb begin
		excl = check_mode_q[MODE_FILT] && (om_s2 != '0) && (om_scaled > ooc_prod_s2);
		thr_fail = (cm_s2 == '0)
			|| ((SW + MASK_W)'(ctx_all_s2) < (SW + MASK_W)'(min_ctx_count_q))
			|| (cm_scaled < ctx_prod_s2);
		if (excl) verdict_d = VERDICT_EXCL;
		else if (check_mode_q[MODE_THR] && thr_fail) verdict_d = VERDICT_FAIL;
		else verdict_d = VERDICT_PASS;
	end

	logic     out_valid_q;
	verdict_t verdict_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (!stall) out_valid_q <= valid_s2;
	end

	always_ff @(posedge clk) begin
		if (!stall && valid_s2) verdict_q <= verdict_d;
	end

	assign result.valid   = out_valid_q;
	assign result.verdict = verdict_q;

`ifndef NO_ASSERTIONS
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		beat_acc && read_beat.last |=> (cnt_q[CNT_CM] == '0) && (cnt_q[CNT_CU] == '0)
			&& (cnt_q[CNT_OM] == '0) && (cnt_q[CNT_OU] == '0))
		else $error("counters not cleared after last beat");

	a_last_enters_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		beat_acc && read_beat.last |=> valid_s1)
		else $error("closed read did not enter the pipe");

	a_count_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		beat_acc && !read_beat.last |=> (cnt_q[CNT_CM] >= $past(cnt_q[CNT_CM]))
			&& (cnt_q[CNT_OM] >= $past(cnt_q[CNT_OM])))
		else $error("counter decreased within a read");

	a_stall_freezes: assert property (@(posedge clk) disable iff (!arst_n)
		stall |=> $stable(valid_s1) && $stable(valid_s2))
		else $error("pipe moved during a stall");

	a_verdict_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (verdict_q == VERDICT_FAIL) || (verdict_q == VERDICT_PASS)
			|| (verdict_q == VERDICT_EXCL))
		else $error("undefined verdict code");
`endif

endmodule
